// ===== rtl/weighted_histogram_1d_with_moments_macros.svh =====
// Assertion macros shared by the weighted histogram RTL.
// Depends on: a clock named clk and an active-low reset named rst_n in the using module.
`ifndef WEIGHTED_HISTOGRAM_1D_WITH_MOMENTS_MACROS_SVH
`define WEIGHTED_HISTOGRAM_1D_WITH_MOMENTS_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define WH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger
`define WH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/whist_pkg.sv =====
// Shared types, codes and saturating helpers for the weighted histogram.
// Used by the divider, the moment unit, the top module and the testbench; depends on nothing.
package whist_pkg;

  localparam int DEF_MAX_BINS = 256;
  localparam int COORD_W      = 16;
  localparam int BIN_W        = 48;
  localparam int SUM_W        = 64;
  localparam int ENTRY_W      = 32;
  localparam int SEL_W        = 9;
  localparam int STAT_SEL_W   = 3;
  localparam int APB_AW       = 4;
  localparam int APB_DW       = 32;

  typedef enum logic [1:0] {
    OP_FILL = 2'd0,
    OP_BIN  = 2'd1,
    OP_STAT = 2'd2,
    OP_NOP  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_SUM_W   = 3'd0,
    ST_SUM_W2  = 3'd1,
    ST_SUM_WX  = 3'd2,
    ST_SUM_WX2 = 3'd3,
    ST_ENTRIES = 3'd4
  } stat_sel_t;

  typedef enum logic [1:0] {
    REG_RANGE_LOW  = 2'd0,
    REG_RANGE_HIGH = 2'd1,
    REG_BINS       = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PREP, S_MUL2, S_DIV, S_RD, S_WR, S_BRD, S_BRES, S_SRES
  } state_t;

  // Steps of the moment unit
  typedef struct packed {
    logic load;
    logic mul2;
    logic commit;
  } mom_ctl_t;

  typedef struct packed {
    logic        [ENTRY_W-1:0] entries;
    logic signed [BIN_W-1:0]   sum_w;
    logic signed [SUM_W-1:0]   sum_w2;
    logic signed [SUM_W-1:0]   sum_wx;
    logic signed [SUM_W-1:0]   sum_wx2;
  } stats_t;

  function automatic logic signed [BIN_W-1:0] sat_add48(input logic signed [BIN_W-1:0] a,
                                                        input logic signed [BIN_W-1:0] b);
    logic signed [BIN_W:0] s;
    s = {a[BIN_W-1], a} + {b[BIN_W-1], b};
    if (s[BIN_W] != s[BIN_W-1]) begin
      sat_add48 = s[BIN_W] ? {1'b1, {(BIN_W-1){1'b0}}} : {1'b0, {(BIN_W-1){1'b1}}};
    end else begin
      sat_add48 = s[BIN_W-1:0];
    end
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add64(input logic signed [SUM_W-1:0] a,
                                                        input logic signed [SUM_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add64 = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add64 = s[SUM_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/whist_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module whist_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 258
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/whist_div.sv =====
// Bit-serial restoring divider that yields the regular bin offset.
// Depends on whist_pkg for the coordinate width.
module whist_div #(
  parameter int DVD_W = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DVD_W-1:0]              dividend,
  input  logic [whist_pkg::COORD_W-1:0] divisor,
  output logic                          busy,
  output logic                          done,
  output logic [DVD_W-1:0]              quotient
);
  import whist_pkg::*;

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic [COORD_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0]   quo_r, quo_nxt;
  logic [COORD_W-1:0] div_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r, done_r;
  logic [COORD_W:0]   shifted;
  logic [COORD_W:0]   diff;
  logic               ge;

  // One quotient bit per cycle
  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    diff    = shifted - {1'b0, div_r};
    ge      = (shifted >= {1'b0, div_r});
    rem_nxt = ge ? diff[COORD_W-1:0] : shifted[COORD_W-1:0];
    quo_nxt = {quo_r[DVD_W-2:0], ge};
  end

  // Control: load on start, count bits, flag the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/whist_mom.sv =====
// Moment unit: products of weight and coordinate and the saturating sums.
// Depends on whist_pkg for widths, the control struct and the saturating adders.
module whist_mom (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  whist_pkg::mom_ctl_t                  ctl,
  input  logic signed [whist_pkg::COORD_W-1:0] coord,
  input  logic signed [whist_pkg::COORD_W-1:0] weight,
  output whist_pkg::stats_t                    stats
);
  import whist_pkg::*;

  logic signed [2*COORD_W-1:0] ww_r, wx_r;
  logic signed [3*COORD_W-1:0] wxx_r;
  stats_t                      stats_r;

  // First products, then the cubic term from the registered w*x
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ww_r <= weight * weight;
      wx_r <= weight * coord;
    end
    if (ctl.mul2) begin
      wxx_r <= wx_r * coord;
    end
  end

  // Accumulate with saturation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stats_r <= '0;
    end else if (ctl.commit) begin
      if (stats_r.entries != {ENTRY_W{1'b1}}) begin
        stats_r.entries <= stats_r.entries + 1'b1;
      end
      stats_r.sum_w   <= sat_add48(stats_r.sum_w,
                                   {{(BIN_W-COORD_W){weight[COORD_W-1]}}, weight});
      stats_r.sum_w2  <= sat_add64(stats_r.sum_w2,
                                   {{(SUM_W-2*COORD_W){ww_r[2*COORD_W-1]}}, ww_r});
      stats_r.sum_wx  <= sat_add64(stats_r.sum_wx,
                                   {{(SUM_W-2*COORD_W){wx_r[2*COORD_W-1]}}, wx_r});
      stats_r.sum_wx2 <= sat_add64(stats_r.sum_wx2,
                                   {{(SUM_W-3*COORD_W){wxx_r[3*COORD_W-1]}}, wxx_r});
    end
  end

  assign stats = stats_r;

endmodule

// ===== rtl/weighted_histogram_1d_with_moments.sv =====
// Weighted 1D histogram with underflow and overflow bins and weighted moments. Items are
// taken one at a time. A fill that lands in a regular bin steps through the prepare and
// multiply states, the bit-serial divider that finds the bin, then the bin read and write;
// a fill into underflow or overflow skips the divider. A bin read reads the memory and
// then loads the output register, a statistic read loads it directly; each read ends with
// the result in the output register. A read whose result finds the output register still
// stalled waits there until it frees, and no new item is taken meanwhile. After reset the
// bin memory is cleared before items are taken. Registers are written through the APB port.
// Depends on whist_pkg, whist_ram, whist_div, whist_mom and the assertion macro header.
`include "weighted_histogram_1d_with_moments_macros.svh"
module weighted_histogram_1d_with_moments #(
  parameter int MAX_BINS = whist_pkg::DEF_MAX_BINS
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic [1:0]                                 in_opcode,
  input  logic signed [whist_pkg::COORD_W-1:0]       in_coord,
  input  logic signed [whist_pkg::COORD_W-1:0]       in_weight,
  input  logic [whist_pkg::SEL_W-1:0]                in_bin_select,
  input  logic [whist_pkg::STAT_SEL_W-1:0]           in_stat_select,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic signed [whist_pkg::SUM_W-1:0]         out_read_value,
  output logic                                       out_read_kind,
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [whist_pkg::APB_AW-1:0]               paddr,
  input  logic [whist_pkg::APB_DW-1:0]               pwdata,
  output logic [whist_pkg::APB_DW-1:0]               prdata,
  output logic                                       pready
);
  import whist_pkg::*;

  localparam int DEPTH = MAX_BINS + 2;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int DVD_W = COORD_W + IDX_W;

  state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] range_low_r, range_high_r;
  logic [SEL_W-1:0]          bins_r;

  logic signed [COORD_W-1:0] coord_r, weight_r;
  logic [SEL_W-1:0]          bsel_r;
  logic [STAT_SEL_W-1:0]     ssel_r;

  logic [IDX_W-1:0]          eff_bins;
  logic [IDX_W-1:0]          idx_r, clr_r;
  logic                      need_div_r, bin_ok_r;
  logic [DVD_W-1:0]          dvd_r;
  logic [COORD_W-1:0]        span_r;

  logic                      out_valid_r;
  logic signed [SUM_W-1:0]   out_value_r;
  logic                      out_kind_r;
  logic                      out_load;
  logic signed [SUM_W-1:0]   load_value;

  logic                      ram_we, ram_re;
  logic [IDX_W-1:0]          ram_waddr, ram_raddr;
  logic [BIN_W-1:0]          ram_wdata, ram_rdata;

  logic                      div_start, div_busy, div_done;
  logic [DVD_W-1:0]          div_quo;

  mom_ctl_t                  mom_ctl;
  stats_t                    stats;
  logic signed [SUM_W-1:0]   stat_value;

  logic                      in_acc, apb_wr;
  logic                      below, above;
  logic [COORD_W:0]          d_full, span_full;
  logic [IDX_W-1:0]          q_idx;
  logic [31:0]               bsel_ext, eff_lim;

  assign in_acc = in_valid && !in_stall;
  assign apb_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  // Effective bin count: zero acts as one, clamp at MAX_BINS
  always_comb begin
    if (bins_r == '0) begin
      eff_bins = IDX_W'(1);
    end else if (32'(bins_r) > 32'(MAX_BINS)) begin
      eff_bins = IDX_W'(MAX_BINS);
    end else begin
      eff_bins = IDX_W'(bins_r);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= '0;
      range_high_r <= 16'sd32767;
      bins_r       <= SEL_W'(256);
    end else if (apb_wr) begin
      case (paddr[3:2])
        REG_RANGE_LOW:  range_low_r  <= pwdata[COORD_W-1:0];
        REG_RANGE_HIGH: range_high_r <= pwdata[COORD_W-1:0];
        REG_BINS:       bins_r       <= pwdata[SEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RANGE_LOW:  prdata = {{(APB_DW-COORD_W){1'b0}}, range_low_r};
      REG_RANGE_HIGH: prdata = {{(APB_DW-COORD_W){1'b0}}, range_high_r};
      REG_BINS:       prdata = {{(APB_DW-SEL_W){1'b0}}, bins_r};
      default:        prdata = '0;
    endcase
  end

  // Bin classification of the held coordinate
  always_comb begin
    below     = (coord_r < range_low_r);
    above     = (coord_r >= range_high_r);
    d_full    = {coord_r[COORD_W-1], coord_r} - {range_low_r[COORD_W-1], range_low_r};
    span_full = {range_high_r[COORD_W-1], range_high_r} -
                {range_low_r[COORD_W-1], range_low_r};
    q_idx     = div_quo[IDX_W-1:0] + 1'b1;
    bsel_ext  = 32'(bsel_r);
    eff_lim   = 32'(eff_bins) + 32'd1;
  end

  // Hold the item and the per-step working values
  always_ff @(posedge clk) begin
    if (in_acc) begin
      coord_r  <= in_coord;
      weight_r <= in_weight;
      bsel_r   <= in_bin_select;
      ssel_r   <= in_stat_select;
    end
    case (state_r)
      S_PREP: begin
        need_div_r <= !below && !above;
        span_r     <= span_full[COORD_W-1:0];
        dvd_r      <= DVD_W'(d_full[COORD_W-1:0]) * DVD_W'(eff_bins);
        idx_r      <= below ? '0 : eff_bins + 1'b1;
      end
      S_DIV: begin
        if (div_done) begin
          idx_r <= (q_idx > eff_bins) ? eff_bins : q_idx;
        end
      end
      S_BRD: begin
        bin_ok_r <= (bsel_ext <= eff_lim) && (bsel_ext < 32'(DEPTH));
      end
      default: ;
    endcase
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (state_r == S_CLEAR) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer: next state, memory access, divider and moment steps
  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = sat_add48(ram_rdata, {{(BIN_W-COORD_W){weight_r[COORD_W-1]}}, weight_r});
    ram_re    = 1'b0;
    ram_raddr = idx_r;
    div_start = 1'b0;
    mom_ctl   = '0;
    out_load  = 1'b0;
    load_value = '0;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        if (clr_r == IDX_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            OP_FILL: state_nxt = S_PREP;
            OP_BIN:  state_nxt = S_BRD;
            OP_STAT: state_nxt = S_SRES;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_PREP: begin
        mom_ctl.load = 1'b1;
        state_nxt    = S_MUL2;
      end
      S_MUL2: begin
        mom_ctl.mul2 = 1'b1;
        if (need_div_r) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        ram_we         = 1'b1;
        mom_ctl.commit = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_BRD: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(bsel_r);
        state_nxt = S_BRES;
      end
      S_BRES: begin
        load_value = bin_ok_r ? SUM_W'(signed'(ram_rdata)) : '0;
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SRES: begin
        load_value = stat_value;
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Statistic selection
  always_comb begin
    case (ssel_r)
      ST_SUM_W:   stat_value = {{(SUM_W-BIN_W){stats.sum_w[BIN_W-1]}}, stats.sum_w};
      ST_SUM_W2:  stat_value = stats.sum_w2;
      ST_SUM_WX:  stat_value = stats.sum_wx;
      ST_SUM_WX2: stat_value = stats.sum_wx2;
      ST_ENTRIES: stat_value = {{(SUM_W-ENTRY_W){1'b0}}, stats.entries};
      default:    stat_value = '0;
    endcase
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= load_value;
      out_kind_r  <= (state_r == S_SRES);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_read_kind  = out_kind_r;

  whist_ram #(
    .WIDTH (BIN_W),
    .DEPTH (DEPTH)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  whist_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_r),
    .divisor  (span_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  whist_mom u_mom (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mom_ctl),
    .coord  (coord_r),
    .weight (weight_r),
    .stats  (stats)
  );

  `WH_ASSERT_SAME(a_we_re_excl, ram_we, !ram_re, "bin memory read and write in one cycle")
  `WH_ASSERT_SAME(a_out_free, out_load, (!out_valid_r || !out_stall), "result overwritten")
  `WH_ASSERT_NEXT(a_fill_silent, (in_acc && in_opcode == OP_FILL), !out_load, "fill gave a result")
  `WH_ASSERT_SAME(a_wr_idx, (state_r == S_WR), (32'(idx_r) <= eff_lim), "fill bin out of range")
  `WH_ASSERT_SAME(a_div_start, div_start, !div_busy, "divider restarted while busy")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the weighted 1D histogram with moments.
// Drives fills and reads through valid/stall, writes ranges over APB, predicts every read.
// Depends on whist_pkg and the weighted_histogram_1d_with_moments RTL.
`timescale 1ns / 100ps
module tb;
  import whist_pkg::*;

  typedef struct {
    opcode_t              op;
    logic signed [15:0]   coord;
    logic signed [15:0]   weight;
    logic [8:0]           bin_sel;
    logic [2:0]           stat_sel;
  } hist_item_t;

  typedef struct {
    logic signed [63:0] value;
    logic               kind;
  } read_ans_t;

  localparam int LIMIT_CYCLES = 900000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_stall;
  logic [1:0] in_opcode = '0;
  logic signed [15:0] in_coord = '0, in_weight = '0;
  logic [8:0] in_bin_select = '0;
  logic [2:0] in_stat_select = '0;
  logic out_valid, out_stall = 1'b0;
  logic signed [63:0] out_read_value;
  logic out_read_kind;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  weighted_histogram_1d_with_moments DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state
  logic signed [15:0] p_low, p_high;
  logic [8:0]         p_bins;
  logic signed [47:0] p_bin [0:257];
  logic [31:0]        p_entries;
  logic signed [47:0] p_sw;
  logic signed [63:0] p_sw2, p_swx, p_swx2;

  hist_item_t pending_items[$];
  read_ans_t  expected_reads[$];
  int errors = 0, cycles = 0, n_fill = 0, n_reads = 0;
  bit quiet_in = 0, quiet_out = 0;

  function automatic logic signed [47:0] clamp48(input longint a, input longint b);
    longint s;
    s = a + b;
    if (s > 64'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (s < -64'sh8000_0000_0000) return 48'sh8000_0000_0000;
    return s[47:0];
  endfunction

  function automatic logic signed [63:0] clamp64(input longint a, input longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic int active_bins();
    int b;
    b = p_bins;
    if (b < 1) b = 1;
    if (b > 256) b = 256;
    return b;
  endfunction

  // Apply one accepted item to the histogram copy, queue any read answer
  function automatic void predict_histogram(input hist_item_t it);
    longint x, w, lo, hi;
    int nb, idx;
    read_ans_t a;
    x = it.coord; w = it.weight; lo = p_low; hi = p_high; nb = active_bins();
    case (it.op)
      OP_FILL: begin
        if (p_entries != 32'hFFFF_FFFF) p_entries++;
        if (x < lo) idx = 0;
        else if (x >= hi) idx = nb + 1;
        else begin
          idx = 1 + int'(((x - lo) * nb) / (hi - lo));
          if (idx > nb) idx = nb;
        end
        p_bin[idx] = clamp48(p_bin[idx], w);
        p_sw   = clamp48(p_sw, w);
        p_sw2  = clamp64(p_sw2, w * w);
        p_swx  = clamp64(p_swx, w * x);
        p_swx2 = clamp64(p_swx2, w * x * x);
      end
      OP_BIN: begin
        a.kind = 1'b0;
        a.value = (it.bin_sel <= nb + 1) ? 64'(p_bin[it.bin_sel]) : 64'sd0;
        expected_reads.insert(expected_reads.size(), a);
      end
      OP_STAT: begin
        a.kind = 1'b1;
        case (it.stat_sel)
          ST_SUM_W:   a.value = 64'(p_sw);
          ST_SUM_W2:  a.value = p_sw2;
          ST_SUM_WX:  a.value = p_swx;
          ST_SUM_WX2: a.value = p_swx2;
          ST_ENTRIES: a.value = {32'd0, p_entries};
          default:    a.value = 64'sd0;
        endcase
        expected_reads.insert(expected_reads.size(), a);
      end
      default: ;
    endcase
  endfunction

  // Driver: present the head item, advance on acceptance, idle at random
  always @(posedge clk) begin
    hist_item_t it;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_histogram(pending_items.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (pending_items.size() > 0 && (quiet_in || $urandom_range(99) >= 24)) begin
          it = pending_items[0];
          in_valid <= 1'b1;
          in_opcode <= it.op;
          in_coord <= it.coord;
          in_weight <= it.weight;
          in_bin_select <= it.bin_sel;
          in_stat_select <= it.stat_sel;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each read answer with the oldest expectation
  always @(posedge clk) begin
    read_ans_t e;
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_reads++;
        if (expected_reads.size() == 0) begin
          errors++;
          $display("%0t: unexpected item value=%0d kind=%0d", $time, out_read_value,
                   out_read_kind);
        end else begin
          e = expected_reads.pop_front();
          if (e.value !== out_read_value) begin
            errors++;
            $display("%0t: read_value expected %0d actual %0d", $time, e.value, out_read_value);
          end
          if (e.kind !== out_read_kind) begin
            errors++;
            $display("%0t: read_kind expected %0d actual %0d", $time, e.kind, out_read_kind);
          end
        end
      end
      out_stall <= !quiet_out && ($urandom_range(99) < 24);
    end
  end

  // Fail and stop at a cycle limit
  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_item(input opcode_t op, input int x, input int w,
                           input int bsel, input int ssel);
    hist_item_t it;
    it.op = op; it.coord = x[15:0]; it.weight = w[15:0];
    it.bin_sel = bsel[8:0]; it.stat_sel = ssel[2:0];
    if (op == OP_FILL) n_fill++;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic apb_write(input reg_idx_t r, input logic [31:0] d);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= APB_AW'(4 * r); pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (r)
      REG_RANGE_LOW:  p_low = d[15:0];
      REG_RANGE_HIGH: p_high = d[15:0];
      default:        p_bins = d[8:0];
    endcase
  endtask

  // Drain all work, then allow the slowest fill to finish
  task automatic settle();
    while (pending_items.size() > 0 || expected_reads.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_ranges(input int lo, input int hi, input int nb);
    settle();
    apb_write(REG_RANGE_LOW, 32'(lo));
    apb_write(REG_RANGE_HIGH, 32'(hi));
    apb_write(REG_BINS, 32'(nb));
  endtask

  task automatic read_everything();
    for (int s = 0; s < 8; s++) push_item(OP_STAT, 0, 0, 0, s);
  endtask

  // Random phase: mostly fills near the range, reads of used bins
  task automatic random_phase(input int n);
    int r, nb, x;
    nb = active_bins();
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 55) begin
        if ($urandom_range(3) == 0) x = $urandom_range(65535);
        else x = int'(p_low) + $urandom_range(0, (p_high > p_low) ? p_high - p_low : 4);
        push_item(OP_FILL, x, $urandom_range(65535) - 32768, 0, 0);
      end else if (r < 80) begin
        push_item(OP_BIN, 0, 0, ($urandom_range(9) == 0) ? $urandom_range(511)
                                                          : $urandom_range(nb + 1), 0);
      end else if (r < 95) begin
        push_item(OP_STAT, 0, 0, 0, $urandom_range(7));
      end else begin
        push_item(OP_NOP, $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(511), $urandom_range(7));
      end
    end
  endtask

  initial begin
    p_low = 16'sd0; p_high = 16'sd32767; p_bins = 9'd256;
    foreach (p_bin[i]) p_bin[i] = '0;
    p_entries = '0; p_sw = '0; p_sw2 = '0; p_swx = '0; p_swx2 = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every operation, special cases at reset config
    push_item(OP_FILL, -32768, -32768, 0, 0);
    push_item(OP_FILL, 32767, 32767, 0, 0);
    push_item(OP_FILL, 0, 32767, 0, 0);
    push_item(OP_FILL, 32766, -1, 0, 0);
    push_item(OP_NOP, 32767, 32767, 511, 7);
    push_item(OP_BIN, 0, 0, 0, 0);
    push_item(OP_BIN, 0, 0, 1, 0);
    push_item(OP_BIN, 0, 0, 256, 0);
    push_item(OP_BIN, 0, 0, 257, 0);
    push_item(OP_BIN, 0, 0, 511, 0);
    read_everything();

    // Zero bins acts as one; inverted range; oversize bin count
    set_ranges(-100, 100, 0);
    push_item(OP_FILL, 0, 5, 0, 0);
    push_item(OP_BIN, 0, 0, 1, 0);
    push_item(OP_BIN, 0, 0, 2, 0);
    push_item(OP_BIN, 0, 0, 3, 0);
    set_ranges(100, -100, 511);
    push_item(OP_FILL, 0, 7, 0, 0);
    push_item(OP_FILL, 200, 9, 0, 0);
    push_item(OP_BIN, 0, 0, 257, 0);
    push_item(OP_BIN, 0, 0, 0, 0);

    // Back-to-back extreme fills into one bin, large weighted sums
    set_ranges(-32768, 32767, 1);
    quiet_in = 1; quiet_out = 1;
    for (int i = 0; i < 300; i++) push_item(OP_FILL, -32768, -32768, 0, 0);
    read_everything();
    push_item(OP_BIN, 0, 0, 1, 0);
    settle();
    quiet_in = 0; quiet_out = 0;

    // Random phases over several range settings
    set_ranges(-1000, 1000, 10);
    random_phase(280);
    set_ranges(-32768, 32767, 256);
    random_phase(280);
    set_ranges(5, 6, 1);
    random_phase(130);
    set_ranges(-300, 3000, 255);
    random_phase(280);
    set_ranges($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
               $urandom_range(511));
    random_phase(280);
    read_everything();
    settle();

    $display("Covered %0d fills and %0d checked reads over nine range settings,", n_fill,
             n_reads);
    $display("with extreme values, inverted ranges, clamped bin counts and random stalls.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
